[sv/htlp_pkg.sv]
`default_nettype none

package htlp_pkg;

  // Table geometry
  localparam int TableSize = 2048;
  localparam int AddrW     = $clog2(TableSize);
  localparam int CntW      = $clog2(TableSize + 1);
  localparam int LastOdd   = ((TableSize % 2) == 0) ? TableSize - 1 : TableSize - 2;

  // Key sum
  localparam int SumW      = 16;
  localparam logic [7:0] SpaceCode = 8'd32;

  // Command codes of an input beat
  localparam logic CmdChar  = 1'b0;
  localparam logic CmdSweep = 1'b1;

  // Field widths of a result beat
  localparam int SlotOutW  = 11;
  localparam int CntOutW   = 12;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_USED    = 2'd1,
    ST_DELETED = 2'd2
  } slot_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_SWEEP,
    S_DONE
  } state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic [SlotOutW-1:0] slot_index;
    logic                inserted;
    logic [CntOutW-1:0]  used_count;
    logic [CntOutW-1:0]  deleted_count;
  } out_item_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    slot_e            wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

[sv/htlp_ram.sv]
`default_nettype none

module htlp_ram (
  input  logic              clk_i,
  input  htlp_pkg::ram_req_t req_i,
  output htlp_pkg::slot_e   rdata_o
);
  import htlp_pkg::*;

  slot_e mem_q [TableSize];
  slot_e rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[sv/hash_table_linear_probe_insert.sv]
`default_nettype none

// Channel  Signals                              Beat
// -------  -----------------------------------  ------------------------------------
// in       in_valid_i / in_ready_o / in_data_i  command, char_code, last_char
// out      out_valid_o / out_ready_i / out_data_o slot_index, inserted, used/deleted
//
// A character beat that does not end a key gives no result. A key end is accepted,
// then slots are read and checked from the start slot on until an empty or deleted one
// is found or every slot was probed, and the result is loaded. A sweep reads every odd slot.
// After reset the status memory is cleared one slot a cycle.
// A result waits in the output register while the next beat is taken; only the
// completion of a later result stalls on it.

module hash_table_linear_probe_insert (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  htlp_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output htlp_pkg::out_item_t  out_data_o
);
  import htlp_pkg::*;

  state_e           state_q, state_d;
  logic [SumW-1:0]  key_sum_q, key_sum_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  del_q, del_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic             chk_vld_q, chk_vld_d;
  logic             out_valid_q, out_valid_d;

  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] chk_addr_q;
  logic [CntW-1:0]  chk_n_q, chk_n_d;
  logic             iss_done_q, iss_done_d;
  logic [AddrW-1:0] res_slot_q, res_slot_d;
  logic             res_ok_q, res_ok_d;
  out_item_t        out_q, out_d;

  ram_req_t         ram_req;
  slot_e            rdata;

  logic             in_acc;
  logic [SumW-1:0]  sum_next;

  htlp_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (rdata)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Running key sum with the incoming character, spaces skipped
  assign sum_next = (in_data_i.char_code == SpaceCode) ? key_sum_q
                  : key_sum_q + SumW'(in_data_i.char_code);

  // Next state, memory access and bookkeeping
  always_comb begin
    state_d     = state_q;
    key_sum_d   = key_sum_q;
    used_d      = used_q;
    del_d       = del_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q;
    pos_d       = pos_q;
    chk_n_d     = chk_n_q;
    iss_done_d  = iss_done_q;
    res_slot_d  = res_slot_q;
    res_ok_d    = res_ok_q;
    out_d       = out_q;
    ram_req     = '0;

    // Drop the result beat once taken
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
        ram_req.wdata = ST_EMPTY;
        clr_d         = clr_q + AddrW'(1);
        if (clr_q == AddrW'(TableSize - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          if (in_data_i.command == CmdSweep) begin
            pos_d      = AddrW'(1);
            iss_done_d = 1'b0;
            state_d    = S_SWEEP;
          end else if (in_data_i.last_char) begin
            // Start slot is the sum modulo the table size
            pos_d     = AddrW'(32'(sum_next) % TableSize);
            chk_n_d   = '0;
            key_sum_d = '0;
            state_d   = S_PROBE;
          end else begin
            key_sum_d = sum_next;
          end
        end
      end

      S_PROBE: begin
        // Issue the next slot read every cycle, check the one read last cycle
        ram_req.re    = 1'b1;
        ram_req.raddr = pos_q;
        pos_d = (pos_q == AddrW'(TableSize - 1)) ? '0 : pos_q + AddrW'(1);
        if (chk_vld_q) begin
          if (rdata inside {ST_EMPTY, ST_DELETED}) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = chk_addr_q;
            ram_req.wdata = ST_USED;
            used_d        = used_q + CntW'(1);
            if (rdata == ST_DELETED) begin
              del_d = del_q - CntW'(1);
            end
            res_slot_d = chk_addr_q;
            res_ok_d   = 1'b1;
            state_d    = S_DONE;
          end else if (chk_n_q == CntW'(TableSize - 1)) begin
            res_slot_d = '0;
            res_ok_d   = 1'b0;
            state_d    = S_DONE;
          end else begin
            chk_n_d = chk_n_q + CntW'(1);
          end
        end
      end

      S_SWEEP: begin
        // Read odd slots in order, turn used ones into deleted ones
        ram_req.re    = !iss_done_q;
        ram_req.raddr = pos_q;
        if (!iss_done_q) begin
          pos_d      = pos_q + AddrW'(2);
          iss_done_d = (pos_q == AddrW'(LastOdd));
        end
        if (chk_vld_q) begin
          if (rdata == ST_USED) begin
            ram_req.we    = 1'b1;
            ram_req.waddr = chk_addr_q;
            ram_req.wdata = ST_DELETED;
            used_d        = used_q - CntW'(1);
            del_d         = del_q + CntW'(1);
          end
          if (chk_addr_q == AddrW'(LastOdd)) begin
            res_slot_d = '0;
            res_ok_d   = 1'b0;
            state_d    = S_DONE;
          end
        end
      end

      S_DONE: begin
        // Hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d         = 1'b1;
          out_d.slot_index    = SlotOutW'(res_slot_q);
          out_d.inserted      = res_ok_q;
          out_d.used_count    = CntOutW'(used_q);
          out_d.deleted_count = CntOutW'(del_q);
          state_d             = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign chk_vld_d = ram_req.re;

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      key_sum_q   <= '0;
      used_q      <= '0;
      del_q       <= '0;
      clr_q       <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      key_sum_q   <= key_sum_d;
      used_q      <= used_d;
      del_q       <= del_d;
      clr_q       <= clr_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    chk_addr_q <= ram_req.raddr;
    chk_n_q    <= chk_n_d;
    iss_done_q <= iss_done_d;
    res_slot_q <= res_slot_d;
    res_ok_q   <= res_ok_d;
    out_q      <= out_d;
  end

  // Used and deleted slots never exceed the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, used_q} + {1'b0, del_q}) <= (CntW + 1)'(TableSize))
    else $error("slot counts exceed table size");

  // A stored key leaves at least one used slot behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.inserted) |-> (out_data_o.used_count != '0))
    else $error("insert reported with no used slot");

  // The status memory is written only while clearing, probing or sweeping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req.we |-> (state_q == S_CLEAR || state_q == S_PROBE || state_q == S_SWEEP))
    else $error("status write outside a table pass");

  // No stale read check is pending when a new beat is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !chk_vld_q)
    else $error("read check pending in idle");

endmodule

`default_nettype wire
